// ----- rtl/klc_pkg.sv -----
package klc_pkg;

    localparam int CELLS    = 16;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(CELLS);

    localparam logic [7:0]       PIN_MAX  = 8'hFF;
    localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(CELLS - 1);

    // request kinds
    localparam logic [1:0] KIND_GET  = 2'd0;
    localparam logic [1:0] KIND_REL  = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_MISS       = 3'd1;
    localparam logic [2:0] STAT_ALL_PINNED = 3'd2;
    localparam logic [2:0] STAT_BAD_REL    = 3'd3;
    localparam logic [2:0] STAT_PIN_SAT    = 3'd4;

    // update commands broadcast to the cells
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_HIT  = 3'd1;
    localparam logic [2:0] OP_MISS = 3'd2;
    localparam logic [2:0] OP_REL  = 3'd3;
    localparam logic [2:0] OP_FAIL = 3'd4;

    // lookup results, OR-accumulated cell to cell
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic             hit_sat;
        logic             req_pin_zero;
        logic [CELLS-1:0] free_by_rank;
    } look_t;

    // victim report, OR-accumulated cell to cell during the update
    typedef struct packed {
        logic [IDX_W-1:0] vic_idx;
        logic             vic_valid;
    } upd_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] tgt;
        logic [IDX_W-1:0] thr_rank;
        logic [CELLS-1:0] free_by_rank;
    } cmd_t;

    function automatic logic [3:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+3:0] t;
        t = {4'd0, idx};
        return t[3:0];
    endfunction

    function automatic logic [IDX_W-1:0] req_to_idx(input logic [3:0] req);
        logic [IDX_W+3:0] t;
        t = {{IDX_W{1'b0}}, req};
        return t[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/klc_cell.sv -----
module klc_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [klc_pkg::IDX_W-1:0]      cell_idx,
    input  logic [klc_pkg::KEY_BITS-1:0]   key,
    input  logic [3:0]                     cell_req,
    input  klc_pkg::cmd_t                  cmd,
    input  klc_pkg::look_t                 look_in,
    output klc_pkg::look_t                 look_out,
    input  klc_pkg::upd_t                  upd_in,
    output klc_pkg::upd_t                  upd_out
);

    logic [klc_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic                         valid_reg, valid_next;
    logic [7:0]                   pin_reg, pin_next;
    logic [klc_pkg::IDX_W-1:0]    rank_reg, rank_next;

    logic                         match;
    logic                         sel_req;
    logic                         unpinned;
    logic [klc_pkg::CELLS-1:0]    rank_bit;
    logic [klc_pkg::CELLS-1:0]    low_mask;
    logic                         older_free;
    logic                         is_tgt;
    logic                         is_vic;

    assign match    = valid_reg && (key_reg == key);
    assign sel_req  = (klc_pkg::req_to_idx(cell_req) == cell_idx)
                      && (32'(cell_req) < klc_pkg::CELLS);
    assign unpinned = (pin_reg == 8'd0);
    assign rank_bit = klc_pkg::CELLS'(1) << rank_reg;
    assign low_mask = rank_bit - klc_pkg::CELLS'(1);

    // an unpinned cell of lower rank exists: this cell is not the victim and ages
    assign older_free = |(cmd.free_by_rank & low_mask);
    assign is_tgt     = (cmd.tgt == cell_idx);
    assign is_vic     = (cmd.op == klc_pkg::OP_MISS) && unpinned && !older_free;

    always_comb begin
        look_out.hit          = look_in.hit | match;
        look_out.hit_idx      = look_in.hit_idx | (match ? cell_idx : '0);
        look_out.hit_rank     = look_in.hit_rank | (match ? rank_reg : '0);
        look_out.hit_sat      = look_in.hit_sat | (match && (pin_reg == klc_pkg::PIN_MAX));
        look_out.req_pin_zero = look_in.req_pin_zero | (sel_req && unpinned);
        look_out.free_by_rank = look_in.free_by_rank | (unpinned ? rank_bit : '0);

        upd_out.vic_idx   = upd_in.vic_idx | (is_vic ? cell_idx : '0);
        upd_out.vic_valid = upd_in.vic_valid | (is_vic && valid_reg);
    end

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        pin_next   = pin_reg;
        rank_next  = rank_reg;
        unique case (cmd.op)
            klc_pkg::OP_HIT: begin
                if (is_tgt) begin
                    rank_next = klc_pkg::RANK_TOP;
                    if (pin_reg != klc_pkg::PIN_MAX) begin
                        pin_next = pin_reg + 8'd1;
                    end
                end else if (rank_reg > cmd.thr_rank) begin
                    rank_next = rank_reg - klc_pkg::IDX_W'(1);
                end
            end
            klc_pkg::OP_MISS: begin
                if (is_vic) begin
                    key_next   = key;
                    valid_next = 1'b1;
                    pin_next   = 8'd1;
                    rank_next  = klc_pkg::RANK_TOP;
                end else if (older_free) begin
                    rank_next = rank_reg - klc_pkg::IDX_W'(1);
                end
            end
            klc_pkg::OP_REL: begin
                if (is_tgt) begin
                    pin_next = pin_reg - 8'd1;
                end
            end
            klc_pkg::OP_FAIL: begin
                if (is_tgt) begin
                    valid_next = 1'b0;
                    pin_next   = 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pin_reg   <= 8'd0;
            rank_reg  <= cell_idx;
        end else begin
            valid_reg <= valid_next;
            pin_reg   <= pin_next;
            rank_reg  <= rank_next;
        end
    end

endmodule

// ----- rtl/keyed_lru_cache_with_pinning_top.sv -----
// Fully associative LRU cache directory with per-cell pin counts, built as a row
// of cells that each hold one key, valid bit, pin count and recency rank. Every
// request beat returns exactly one result beat. A request passes through a
// lookup pass, where key match, pin state and the set of unpinned ranks ripple
// down the cell row, and then an update pass, where the command is broadcast
// and each cell picks itself as victim and adjusts its own rank. The block
// takes no new request beat while one is in flight until that one's result
// loads; a stalled result holds the next request in the update pass until the
// output register frees up. Keys are compared over the low KEY_BITS bits;
// total_* outputs are the counters after this result.
module keyed_lru_cache_with_pinning_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [63:0] s_key,
    input  logic [3:0]  s_cell_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_slot,
    output logic        m_evicted,
    output logic [31:0] m_total_hits,
    output logic [31:0] m_total_misses,
    output logic [31:0] m_total_evictions
);

    localparam int CELLS = klc_pkg::CELLS;
    localparam int IDX_W = klc_pkg::IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [1:0]                   kind_reg;
    logic [klc_pkg::KEY_BITS-1:0] key_reg;
    logic [3:0]                   req_reg;

    klc_pkg::look_t look_reg;
    klc_pkg::look_t look_chain [CELLS+1];
    klc_pkg::upd_t  upd_chain  [CELLS+1];
    klc_pkg::cmd_t  cmd;

    logic        m_valid_reg;
    logic [2:0]  status_reg, status_next;
    logic [3:0]  slot_reg, slot_next;
    logic        evicted_reg, evicted_next;
    logic [31:0] hit_count_reg, miss_count_reg, evict_count_reg;

    logic             out_free;
    logic             fire;
    logic             accept;
    logic             in_range;
    logic [2:0]       op;
    logic [IDX_W-1:0] tgt;
    logic [IDX_W-1:0] thr_rank;
    logic             is_get;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == ST_UPD) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || fire;
    assign accept   = s_valid && s_ready;
    assign in_range = 32'(req_reg) < CELLS;
    assign is_get   = (kind_reg == klc_pkg::KIND_GET);

    assign look_chain[0] = '0;
    assign upd_chain[0]  = '0;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        klc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .key      (key_reg),
            .cell_req (req_reg),
            .cmd      (cmd),
            .look_in  (look_chain[i]),
            .look_out (look_chain[i+1]),
            .upd_in   (upd_chain[i]),
            .upd_out  (upd_chain[i+1])
        );
    end

    always_comb begin
        op          = klc_pkg::OP_NONE;
        tgt         = '0;
        thr_rank    = '0;
        status_next = klc_pkg::STAT_OK;
        slot_next   = 4'd0;
        unique case (kind_reg)
            klc_pkg::KIND_GET: begin
                if (look_reg.hit) begin
                    op          = klc_pkg::OP_HIT;
                    tgt         = look_reg.hit_idx;
                    thr_rank    = look_reg.hit_rank;
                    status_next = look_reg.hit_sat ? klc_pkg::STAT_PIN_SAT : klc_pkg::STAT_OK;
                    slot_next   = klc_pkg::to_slot(look_reg.hit_idx);
                end else if (|look_reg.free_by_rank) begin
                    op          = klc_pkg::OP_MISS;
                    status_next = klc_pkg::STAT_MISS;
                    slot_next   = klc_pkg::to_slot(upd_chain[CELLS].vic_idx);
                end else begin
                    status_next = klc_pkg::STAT_ALL_PINNED;
                end
            end
            klc_pkg::KIND_REL: begin
                slot_next = req_reg;
                if (in_range && !look_reg.req_pin_zero) begin
                    op  = klc_pkg::OP_REL;
                    tgt = klc_pkg::req_to_idx(req_reg);
                end else begin
                    status_next = klc_pkg::STAT_BAD_REL;
                end
            end
            klc_pkg::KIND_FAIL: begin
                slot_next = req_reg;
                if (in_range) begin
                    op  = klc_pkg::OP_FAIL;
                    tgt = klc_pkg::req_to_idx(req_reg);
                end else begin
                    status_next = klc_pkg::STAT_BAD_REL;
                end
            end
            default: begin
            end
        endcase
        evicted_next = (op == klc_pkg::OP_MISS) && upd_chain[CELLS].vic_valid;

        // cells act only on the cycle the result is loaded
        cmd.op           = fire ? op : klc_pkg::OP_NONE;
        cmd.tgt          = tgt;
        cmd.thr_rank     = thr_rank;
        cmd.free_by_rank = look_reg.free_by_rank;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    state_next = s_valid ? ST_LOOK : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind;
            key_reg  <= s_key[klc_pkg::KEY_BITS-1:0];
            req_reg  <= s_cell_req;
        end
        if (state_reg == ST_LOOK) begin
            look_reg <= look_chain[CELLS];
        end
        if (fire) begin
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            evicted_reg <= evicted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            hit_count_reg   <= 32'd0;
            miss_count_reg  <= 32'd0;
            evict_count_reg <= 32'd0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
                if (is_get && look_reg.hit) begin
                    hit_count_reg <= hit_count_reg + 32'd1;
                end
                if (is_get && !look_reg.hit) begin
                    miss_count_reg <= miss_count_reg + 32'd1;
                end
                if (evicted_next) begin
                    evict_count_reg <= evict_count_reg + 32'd1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // counters change only when a new result loads, so they track the held beat
    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_slot            = slot_reg;
    assign m_evicted         = evicted_reg;
    assign m_total_hits      = hit_count_reg;
    assign m_total_misses    = miss_count_reg;
    assign m_total_evictions = evict_count_reg;

endmodule

// ----- bench/keyed_lru_cache_with_pinning_top_tb.sv -----
`timescale 1ns / 100ps

module keyed_lru_cache_with_pinning_top_tb;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_TARGET = 900;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [3:0]  cell_req;
        logic        hold_for_drain;
    } cache_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic        evicted;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } cache_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [63:0] s_key = '0;
    logic [3:0]  s_cell_req = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_slot;
    logic        m_evicted;
    logic [31:0] m_total_hits;
    logic [31:0] m_total_misses;
    logic [31:0] m_total_evictions;

    // shadow copy of the cache directory
    logic [klc_pkg::KEY_BITS-1:0] c_key [klc_pkg::CELLS];
    logic                         c_valid [klc_pkg::CELLS];
    logic [7:0]                   c_pin [klc_pkg::CELLS];
    logic [klc_pkg::IDX_W-1:0]    c_rank [klc_pkg::CELLS];
    logic [31:0]                  n_hits, n_misses, n_evicts;

    cache_req_t pending_reqs[$];
    cache_res_t pending_results[$];
    logic [63:0] key_pool [32];

    bit drain_next = 1'b0;
    bit req_taken = 1'b0;
    bit rsp_taken = 1'b0;
    bit long_hold_done = 1'b0;
    int tx_gap = 0, tx_calm = 0;
    int rx_stall = 0, rx_calm = 0;
    int beats_in = 0, results_seen = 0;
    int mismatches = 0;

    keyed_lru_cache_with_pinning_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_key             (s_key),
        .s_cell_req        (s_cell_req),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_slot            (m_slot),
        .m_evicted         (m_evicted),
        .m_total_hits      (m_total_hits),
        .m_total_misses    (m_total_misses),
        .m_total_evictions (m_total_evictions)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string res_text(input cache_res_t r);
        return $sformatf("status=%0d slot=%0d evicted=%0b hits=%0d misses=%0d evictions=%0d",
                         r.status, r.slot, r.evicted, r.hits, r.misses, r.evicts);
    endfunction

    task flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    task queue_req(input logic [1:0] kind, input logic [63:0] key, input logic [3:0] req);
        cache_req_t q;
        q.kind = kind;
        q.key = key;
        q.cell_req = req;
        q.hold_for_drain = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(q);
    endtask

    // move a cell to the top of the recency order, shifting the ones above it down
    task promote(input int c);
        int i;
        logic [klc_pkg::IDX_W-1:0] r;
        r = c_rank[c];
        for (i = 0; i < klc_pkg::CELLS; i++)
            if (c_rank[i] > r) c_rank[i] = c_rank[i] - klc_pkg::IDX_W'(1);
        c_rank[c] = klc_pkg::RANK_TOP;
    endtask

    task cache_outcome(input logic [1:0] kind, input logic [63:0] key, input logic [3:0] req,
                       output cache_res_t res);
        int i, hit_at, vic_at;
        logic [klc_pkg::IDX_W-1:0] vic_rank;
        res = '0;
        hit_at = -1;
        vic_at = -1;
        vic_rank = '0;
        case (kind)
            klc_pkg::KIND_GET: begin
                for (i = 0; i < klc_pkg::CELLS; i++)
                    if (hit_at < 0 && c_valid[i] && c_key[i] == key[klc_pkg::KEY_BITS-1:0])
                        hit_at = i;
                if (hit_at >= 0) begin
                    n_hits++;
                    if (c_pin[hit_at] == klc_pkg::PIN_MAX) begin
                        res.status = klc_pkg::STAT_PIN_SAT;
                    end else begin
                        c_pin[hit_at] = c_pin[hit_at] + 8'd1;
                        res.status = klc_pkg::STAT_OK;
                    end
                    promote(hit_at);
                    res.slot = hit_at[3:0];
                end else begin
                    n_misses++;
                    // victim: least recent cell with no pins
                    for (i = 0; i < klc_pkg::CELLS; i++)
                        if (c_pin[i] == 8'd0 && (vic_at < 0 || c_rank[i] < vic_rank)) begin
                            vic_at = i;
                            vic_rank = c_rank[i];
                        end
                    if (vic_at < 0) begin
                        res.status = klc_pkg::STAT_ALL_PINNED;
                    end else begin
                        if (c_valid[vic_at]) begin
                            n_evicts++;
                            res.evicted = 1'b1;
                        end
                        c_key[vic_at] = key[klc_pkg::KEY_BITS-1:0];
                        c_valid[vic_at] = 1'b1;
                        c_pin[vic_at] = 8'd1;
                        promote(vic_at);
                        res.status = klc_pkg::STAT_MISS;
                        res.slot = vic_at[3:0];
                    end
                end
            end
            klc_pkg::KIND_REL: begin
                res.slot = req;
                if (req >= klc_pkg::CELLS || c_pin[req] == 8'd0) begin
                    res.status = klc_pkg::STAT_BAD_REL;
                end else begin
                    c_pin[req] = c_pin[req] - 8'd1;
                    res.status = klc_pkg::STAT_OK;
                end
            end
            klc_pkg::KIND_FAIL: begin
                res.slot = req;
                if (req >= klc_pkg::CELLS) begin
                    res.status = klc_pkg::STAT_BAD_REL;
                end else begin
                    c_valid[req] = 1'b0;
                    c_pin[req] = 8'd0;
                    res.status = klc_pkg::STAT_OK;
                end
            end
            default: ;
        endcase
        res.hits = n_hits;
        res.misses = n_misses;
        res.evicts = n_evicts;
    endtask

    // request driver: change at the falling edge, hold until the beat is taken
    always @(negedge aclk) begin : drive_req
        cache_req_t nxt;
        bit waiting;
        if (aresetn) begin
            waiting = s_valid && !req_taken;
            if (req_taken) begin
                req_taken = 1'b0;
                if (tx_calm > 0) tx_calm--;
                else if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(15, 50);
                tx_gap = pick_gap(tx_calm > 0);
            end
            if (!waiting) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0 &&
                             !(pending_reqs[0].hold_for_drain && pending_results.size() != 0)) begin
                    nxt = pending_reqs.pop_front();
                    s_kind <= nxt.kind;
                    s_key <= nxt.key;
                    s_cell_req <= nxt.cell_req;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver readiness, with one long hold-off to back up the block
    always @(negedge aclk) begin : drive_ready
        if (aresetn) begin
            if (rsp_taken) begin
                rsp_taken = 1'b0;
                if (rx_calm > 0) rx_calm--;
                else if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(15, 50);
                rx_stall = pick_gap(rx_calm > 0);
            end
            if (!long_hold_done && results_seen >= 400) begin
                long_hold_done = 1'b1;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watch_beats
        cache_res_t want, got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                cache_outcome(s_kind, s_key, s_cell_req, want);
                pending_results.push_back(want);
                req_taken = 1'b1;
                beats_in++;
            end
            if (m_valid && m_ready) begin
                rsp_taken = 1'b1;
                results_seen++;
                got.status = m_status;
                got.slot = m_slot;
                got.evicted = m_evicted;
                got.hits = m_total_hits;
                got.misses = m_total_misses;
                got.evicts = m_total_evictions;
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result %0d with no request outstanding: %s",
                                         results_seen, res_text(got)));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        flag_error($sformatf("result %0d\n  expected %s\n  actual   %s",
                                             results_seen, res_text(want), res_text(got)));
                end
            end
        end
    end

    initial begin : watchdog
        int idle, last_in, last_out;
        idle = 0;
        last_in = 0;
        last_out = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if (beats_in != last_in || results_seen != last_out) idle = 0;
            else idle++;
            last_in = beats_in;
            last_out = results_seen;
        end
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("** keyed_lru_cache_with_pinning_top: FAILED **");
        $finish;
    end

    initial begin : run
        int i, span, base, r;
        for (i = 0; i < klc_pkg::CELLS; i++) begin
            c_key[i] = '0;
            c_valid[i] = 1'b0;
            c_pin[i] = 8'd0;
            c_rank[i] = i[klc_pkg::IDX_W-1:0];
        end
        n_hits = '0;
        n_misses = '0;
        n_evicts = '0;
        for (i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;

        // fill every cell, then one more miss finds nothing to evict
        for (i = 0; i < 16; i++) queue_req(klc_pkg::KIND_GET, key_pool[i], 4'($urandom));
        queue_req(klc_pkg::KIND_GET, key_pool[16], 4'd0);
        queue_req(klc_pkg::KIND_GET, key_pool[1], 4'hF);
        queue_req(klc_pkg::KIND_REL, {$urandom, $urandom}, 4'd15);
        queue_req(klc_pkg::KIND_REL, {$urandom, $urandom}, 4'd15);
        queue_req(klc_pkg::KIND_FAIL, {$urandom, $urandom}, 4'd0);
        queue_req(KIND_SPARE, {$urandom, $urandom}, 4'd15);
        queue_req(klc_pkg::KIND_GET, key_pool[16], 4'd0);
        queue_req(klc_pkg::KIND_GET, key_pool[17], 4'd0);
        queue_req(klc_pkg::KIND_REL, '1, 4'd0);

        // hammer one key until its pin count saturates, then flush every cell
        drain_next = 1'b1;
        for (i = 0; i < 260; i++) queue_req(klc_pkg::KIND_GET, key_pool[20], 4'($urandom));
        for (i = 0; i < klc_pkg::CELLS; i++)
            queue_req(klc_pkg::KIND_FAIL, {$urandom, $urandom}, i[3:0]);

        // random rounds over a sliding window of keys, some narrower than the cache
        while (pending_reqs.size() < RANDOM_TARGET) begin
            span = $urandom_range(6, 31);
            base = $urandom_range(0, 32 - span);
            repeat ($urandom_range(20, 50)) begin
                r = $urandom_range(0, 99);
                if (r < 48)
                    queue_req(klc_pkg::KIND_GET, key_pool[base + $urandom_range(0, span - 1)],
                              4'($urandom));
                else if (r < 52)
                    queue_req(klc_pkg::KIND_GET, {$urandom, $urandom}, 4'($urandom));
                else if (r < 90)
                    queue_req(klc_pkg::KIND_REL, {$urandom, $urandom}, 4'($urandom));
                else if (r < 97)
                    queue_req(klc_pkg::KIND_FAIL, {$urandom, $urandom}, 4'($urandom));
                else
                    queue_req(KIND_SPARE, {$urandom, $urandom}, 4'($urandom));
            end
            if ($urandom_range(0, 3) == 0)
                for (i = 0; i < klc_pkg::CELLS; i++)
                    queue_req(klc_pkg::KIND_FAIL, {$urandom, $urandom}, i[3:0]);
        end

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (mismatches == 0)
            $display("** keyed_lru_cache_with_pinning_top: PASSED **");
        else
            $display("** keyed_lru_cache_with_pinning_top: FAILED **");
        $finish;
    end

endmodule

// ----- keyed_lru_cache_with_pinning_top.f -----
rtl/klc_pkg.sv
rtl/klc_cell.sv
rtl/keyed_lru_cache_with_pinning_top.sv
bench/keyed_lru_cache_with_pinning_top_tb.sv
